/* hdl/bfem_pkg.sv */
package bfem_pkg;

  localparam int PIX_W     = 8;
  localparam int ROW_OUT_W = 12;
  localparam int COL_OUT_W = 10;
  localparam int FW_W      = 11;
  localparam int FH_W      = 13;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;

  // neighbourhood arithmetic
  localparam int WIN_N    = 9;
  localparam int SUM_W    = 12;
  localparam int CNT_W    = 4;
  localparam int RECIP_W  = 17;
  localparam int RECIP_SH = 16;
  localparam int N_SLOT   = 4;

  // register index, taken from paddr[2]
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef logic [WIN_N-1:0][PIX_W-1:0] win_t;

  // position of an item relative to the frame edges
  typedef struct packed {
    logic r_ge1;
    logic r_ge2;
    logic r_last;
    logic c_ge1;
    logic c_ge2;
    logic c_last;
  } pos_flags_t;

endpackage

/* hdl/bfem_cfg.sv */
module bfem_cfg #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096,
  parameter int CW         = 10,
  parameter int RW         = 12
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bfem_pkg::APB_AW-1:0]    paddr,
  input  logic [bfem_pkg::APB_DW-1:0]    pwdata,
  output logic [bfem_pkg::APB_DW-1:0]    prdata,
  output logic                           pready,
  output logic [CW-1:0]                  w_last,
  output logic [RW-1:0]                  h_last,
  output logic                           restart
);

  localparam int W_RST_LAST = (MAX_WIDTH < 5 ? MAX_WIDTH : 5) - 1;
  localparam int H_RST_LAST = (MAX_HEIGHT < 5 ? MAX_HEIGHT : 5) - 1;

  localparam logic REG_FRAME_WIDTH_SEL  = bfem_pkg::REG_FRAME_WIDTH;
  localparam logic REG_FRAME_HEIGHT_SEL = bfem_pkg::REG_FRAME_HEIGHT;

  logic [bfem_pkg::FW_W-1:0] fw_r, fw_nxt;
  logic [bfem_pkg::FH_W-1:0] fh_r, fh_nxt;
  logic [CW-1:0]             w_last_r, w_last_nxt;
  logic [RW-1:0]             h_last_r, h_last_nxt;
  logic                      wr;
  logic [bfem_pkg::FW_W-1:0] wd_w;
  logic [bfem_pkg::FH_W-1:0] wd_h;

  assign pready  = 1'b1;
  assign wr      = psel & penable & pwrite;
  assign restart = wr;
  assign wd_w    = pwdata[bfem_pkg::FW_W-1:0];
  assign wd_h    = pwdata[bfem_pkg::FH_W-1:0];

  always_comb begin
    fw_nxt     = fw_r;
    fh_nxt     = fh_r;
    w_last_nxt = w_last_r;
    h_last_nxt = h_last_r;
    if (wr) begin
      unique case (paddr[2])
        REG_FRAME_WIDTH_SEL: begin
          fw_nxt = wd_w;
          // zero acts as one, oversize clamps to the store depth
          if (wd_w == '0) begin
            w_last_nxt = '0;
          end else if (32'(wd_w) > 32'(MAX_WIDTH)) begin
            w_last_nxt = CW'(MAX_WIDTH - 1);
          end else begin
            w_last_nxt = CW'(wd_w - bfem_pkg::FW_W'(1));
          end
        end
        REG_FRAME_HEIGHT_SEL: begin
          fh_nxt = wd_h;
          if (wd_h == '0) begin
            h_last_nxt = '0;
          end else if (32'(wd_h) > 32'(MAX_HEIGHT)) begin
            h_last_nxt = RW'(MAX_HEIGHT - 1);
          end else begin
            h_last_nxt = RW'(wd_h - bfem_pkg::FH_W'(1));
          end
        end
        default: begin
          fw_nxt = fw_r;
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FRAME_WIDTH_SEL:  prdata = {{(bfem_pkg::APB_DW-bfem_pkg::FW_W){1'b0}}, fw_r};
      REG_FRAME_HEIGHT_SEL: prdata = {{(bfem_pkg::APB_DW-bfem_pkg::FH_W){1'b0}}, fh_r};
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r     <= bfem_pkg::FW_W'(5);
      fh_r     <= bfem_pkg::FH_W'(5);
      w_last_r <= CW'(W_RST_LAST);
      h_last_r <= RW'(H_RST_LAST);
    end else begin
      fw_r     <= fw_nxt;
      fh_r     <= fh_nxt;
      w_last_r <= w_last_nxt;
      h_last_r <= h_last_nxt;
    end
  end

  assign w_last = w_last_r;
  assign h_last = h_last_r;

endmodule

/* hdl/bfem_front.sv */
module bfem_front #(
  parameter int MAX_WIDTH = 1024,
  parameter int CW        = 10,
  parameter int RW        = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bfem_pkg::PIX_W-1:0]    in_pixel_in,
  input  logic [CW-1:0]                 w_last,
  input  logic [RW-1:0]                 h_last,
  input  logic                          restart,
  input  logic                          s2_ready,
  output logic                          s1_valid,
  output logic [bfem_pkg::PIX_W-1:0]    s1_px,
  output logic [bfem_pkg::PIX_W-1:0]    s1_a,
  output logic [bfem_pkg::PIX_W-1:0]    s1_b,
  output logic [RW-1:0]                 s1_row,
  output logic [CW-1:0]                 s1_col,
  output bfem_pkg::pos_flags_t          s1_flags
);

  localparam int PW = bfem_pkg::PIX_W;

  // each entry holds the pixel one row up (upper half) and two rows up
  logic [2*PW-1:0] store [MAX_WIDTH];

  logic [RW-1:0]        row_r, row_nxt;
  logic [CW-1:0]        col_r, col_nxt;
  logic                 s1_valid_r, s1_valid_nxt;
  logic [PW-1:0]        s1_px_r;
  logic [RW-1:0]        s1_row_r;
  logic [CW-1:0]        s1_col_r;
  bfem_pkg::pos_flags_t s1_flags_r;
  logic [2*PW-1:0]      rd_r;
  logic                 fwd_r;
  logic [PW-1:0]        fwd_px_r;
  logic [PW-1:0]        fwd_a_r;
  logic                 accept;
  logic                 s1_adv;
  logic [PW-1:0]        a_eff;
  logic [PW-1:0]        b_eff;

  assign in_ready = !s1_valid_r || s2_ready;
  assign accept   = in_valid && in_ready;
  assign s1_adv   = s1_valid_r && s2_ready;

  // one-column frames read the entry the item ahead writes in the same cycle
  assign a_eff = fwd_r ? fwd_px_r : rd_r[2*PW-1:PW];
  assign b_eff = fwd_r ? fwd_a_r  : rd_r[PW-1:0];

  always_comb begin
    row_nxt      = row_r;
    col_nxt      = col_r;
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    if (restart) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (accept) begin
      if (col_r == w_last) begin
        col_nxt = '0;
        row_nxt = (row_r == h_last) ? '0 : row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r      <= '0;
      col_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px_r           <= in_pixel_in;
      s1_row_r          <= row_r;
      s1_col_r          <= col_r;
      s1_flags_r.r_ge1  <= (row_r != '0);
      s1_flags_r.r_ge2  <= (row_r > RW'(1));
      s1_flags_r.r_last <= (row_r == h_last);
      s1_flags_r.c_ge1  <= (col_r != '0);
      s1_flags_r.c_ge2  <= (col_r > CW'(1));
      s1_flags_r.c_last <= (col_r == w_last);
      fwd_r             <= s1_adv && (s1_col_r == col_r);
      fwd_px_r          <= s1_px_r;
      fwd_a_r           <= a_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r <= store[col_r];
    end
    if (s1_adv) begin
      store[s1_col_r] <= {s1_px_r, a_eff};
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_px    = s1_px_r;
  assign s1_a     = a_eff;
  assign s1_b     = b_eff;
  assign s1_row   = s1_row_r;
  assign s1_col   = s1_col_r;
  assign s1_flags = s1_flags_r;

endmodule

/* hdl/bfem_window.sv */
module bfem_window #(
  parameter int CW = 10,
  parameter int RW = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          s1_valid,
  input  logic [bfem_pkg::PIX_W-1:0]    s1_px,
  input  logic [bfem_pkg::PIX_W-1:0]    s1_a,
  input  logic [bfem_pkg::PIX_W-1:0]    s1_b,
  input  logic [RW-1:0]                 s1_row,
  input  logic [CW-1:0]                 s1_col,
  input  bfem_pkg::pos_flags_t          s1_flags,
  input  logic                          buf_free,
  output logic                          s2_ready,
  output logic                          s2_valid,
  output bfem_pkg::win_t                s2_win,
  output logic [RW-1:0]                 s2_row,
  output logic [CW-1:0]                 s2_col,
  output bfem_pkg::pos_flags_t          s2_flags
);

  logic                 s2_valid_r, s2_valid_nxt;
  bfem_pkg::win_t       win_r, win_nxt;
  logic [RW-1:0]        s2_row_r;
  logic [CW-1:0]        s2_col_r;
  bfem_pkg::pos_flags_t s2_flags_r;
  logic                 s1_adv;

  assign s2_ready = !s2_valid_r || buf_free;
  assign s1_adv   = s1_valid && s2_ready;

  always_comb begin
    s2_valid_nxt = s2_valid_r;
    win_nxt      = win_r;
    if (s1_adv) begin
      s2_valid_nxt = 1'b1;
      // shift left one column, new column enters on the right
      for (int i = 0; i < 3; i++) begin
        win_nxt[i*3]   = win_r[i*3+1];
        win_nxt[i*3+1] = win_r[i*3+2];
      end
      win_nxt[2] = s1_b;
      win_nxt[5] = s1_a;
      win_nxt[8] = s1_px;
    end else if (buf_free) begin
      s2_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      win_r      <= '0;
    end else begin
      s2_valid_r <= s2_valid_nxt;
      win_r      <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_row_r   <= s1_row;
      s2_col_r   <= s1_col;
      s2_flags_r <= s1_flags;
    end
  end

  assign s2_valid = s2_valid_r;
  assign s2_win   = win_r;
  assign s2_row   = s2_row_r;
  assign s2_col   = s2_col_r;
  assign s2_flags = s2_flags_r;

endmodule

/* hdl/bfem_mean.sv */
module bfem_mean #(
  parameter int CW = 10,
  parameter int RW = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              s2_valid,
  input  bfem_pkg::win_t                    s2_win,
  input  logic [RW-1:0]                     s2_row,
  input  logic [CW-1:0]                     s2_col,
  input  bfem_pkg::pos_flags_t              s2_flags,
  output logic                              buf_free,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bfem_pkg::PIX_W-1:0]        out_mean_out,
  output logic [bfem_pkg::ROW_OUT_W-1:0]    out_row,
  output logic [bfem_pkg::COL_OUT_W-1:0]    out_col,
  output logic                              out_run_last,
  output logic                              out_frame_end
);

  localparam int NS = bfem_pkg::N_SLOT;
  localparam int PW = bfem_pkg::PIX_W;
  localparam int SW = bfem_pkg::SUM_W;
  localparam int KW = bfem_pkg::CNT_W;
  localparam int MW = bfem_pkg::SUM_W + bfem_pkg::RECIP_W;

  // neighbours of window position (wi,wj) that lie in the window and the frame
  function automatic logic [bfem_pkg::WIN_N-1:0] nb_mask(input int wi, input int wj,
                                                        input logic [2:0] rok,
                                                        input logic [2:0] cok);
    logic [bfem_pkg::WIN_N-1:0] m;
    m = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        m[i*3+j] = (i >= wi - 1) && (i <= wi + 1) && (j >= wj - 1) && (j <= wj + 1)
                   && rok[i] && cok[j];
      end
    end
    return m;
  endfunction

  // ceil(2^16 / n): exact for every sum of up to nine pixels
  function automatic logic [bfem_pkg::RECIP_W-1:0] recip(input logic [KW-1:0] n);
    logic [bfem_pkg::RECIP_W-1:0] q;
    case (n)
      4'd1:    q = 17'd65536;
      4'd2:    q = 17'd32768;
      4'd3:    q = 17'd21846;
      4'd4:    q = 17'd16384;
      4'd5:    q = 17'd13108;
      4'd6:    q = 17'd10923;
      4'd7:    q = 17'd9363;
      4'd8:    q = 17'd8192;
      4'd9:    q = 17'd7282;
      default: q = '0;
    endcase
    return q;
  endfunction

  logic [2:0]                 rok;
  logic [2:0]                 cok;
  logic [NS-1:0]              en;
  logic [NS-1:0]              last;
  logic [bfem_pkg::WIN_N-1:0] nmask [NS];
  logic [SW-1:0]              nsum  [NS];
  logic [KW-1:0]              ncnt  [NS];
  logic [MW-1:0]              nprod [NS];
  logic [RW-1:0]              row_m1;
  logic [CW-1:0]              col_m1;

  logic [NS-1:0]                   mask_r, mask_nxt;
  logic [PW-1:0]                   slot_mean_r [NS];
  logic [bfem_pkg::ROW_OUT_W-1:0]  slot_row_r  [NS];
  logic [bfem_pkg::COL_OUT_W-1:0]  slot_col_r  [NS];
  logic [NS-1:0]                   slot_last_r;
  logic                            frame_end_r;
  logic [1:0]                      sel;
  logic                            load;
  logic                            pop;
  logic [NS-1:0]                   mask_pop;

  assign rok = {1'b1, s2_flags.r_ge1, s2_flags.r_ge2};
  assign cok = {1'b1, s2_flags.c_ge1, s2_flags.c_ge2};

  // slots in raster order: (r-1,c-1) (r-1,c) (r,c-1) (r,c)
  assign en[0] = s2_flags.r_ge1  && s2_flags.c_ge1;
  assign en[1] = s2_flags.r_ge1  && s2_flags.c_last;
  assign en[2] = s2_flags.r_last && s2_flags.c_ge1;
  assign en[3] = s2_flags.r_last && s2_flags.c_last;

  assign last[3] = en[3];
  assign last[2] = en[2] && !en[3];
  assign last[1] = en[1] && !(|en[3:2]);
  assign last[0] = en[0] && !(|en[3:1]);

  assign row_m1 = s2_row - RW'(1);
  assign col_m1 = s2_col - CW'(1);

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      nmask[k] = nb_mask(1 + k / 2, 1 + k % 2, rok, cok);
      nsum[k]  = '0;
      ncnt[k]  = '0;
      for (int i = 0; i < bfem_pkg::WIN_N; i++) begin
        nsum[k] = nsum[k] + (nmask[k][i] ? SW'(s2_win[i]) : SW'(0));
        ncnt[k] = ncnt[k] + KW'(nmask[k][i]);
      end
      nprod[k] = MW'(nsum[k]) * MW'(recip(ncnt[k]));
    end
  end

  assign mask_pop = mask_r & (mask_r - NS'(1));
  assign out_valid = |mask_r;
  assign pop       = out_valid && out_ready;
  // room for a new item once at most the last pending result leaves now
  assign buf_free  = (mask_r == '0) || ((mask_pop == '0) && out_ready);
  assign load      = s2_valid && buf_free;

  always_comb begin
    mask_nxt = mask_r;
    if (load) begin
      mask_nxt = en;
    end else if (pop) begin
      mask_nxt = mask_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else begin
      mask_r <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int k = 0; k < NS; k++) begin
        slot_mean_r[k] <= nprod[k][bfem_pkg::RECIP_SH +: PW];
        slot_row_r[k]  <= bfem_pkg::ROW_OUT_W'((k >= 2) ? s2_row : row_m1);
        slot_col_r[k]  <= bfem_pkg::COL_OUT_W'((k % 2 == 1) ? s2_col : col_m1);
      end
      slot_last_r <= last;
      frame_end_r <= s2_flags.r_last && s2_flags.c_last;
    end
  end

  // lowest pending slot goes first
  always_comb begin
    sel = '0;
    for (int k = NS - 1; k >= 0; k--) begin
      if (mask_r[k]) begin
        sel = 2'(k);
      end
    end
  end

  assign out_mean_out  = slot_mean_r[sel];
  assign out_row       = slot_row_r[sel];
  assign out_col       = slot_col_r[sel];
  assign out_run_last  = slot_last_r[sel];
  assign out_frame_end = frame_end_r;

endmodule

/* hdl/box_filter_3x3_edge_mean.sv */
// path: an accepted item goes through the front, window and result registers in turn
// throughput: one item per cycle without stalls; results leave one per cycle, so
//   an item in the last row or column gives up to two, the final pixel of a frame four
// reset: synchronous, active low; clears counters, window and result queue,
//   restores width and height to 5; the line stores keep their contents
module box_filter_3x3_edge_mean #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bfem_pkg::APB_AW-1:0]       paddr,
  input  logic [bfem_pkg::APB_DW-1:0]       pwdata,
  output logic [bfem_pkg::APB_DW-1:0]       prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bfem_pkg::PIX_W-1:0]        in_pixel_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bfem_pkg::PIX_W-1:0]        out_mean_out,
  output logic [bfem_pkg::ROW_OUT_W-1:0]    out_row,
  output logic [bfem_pkg::COL_OUT_W-1:0]    out_col,
  output logic                              out_run_last,
  output logic                              out_frame_end
);

  localparam int CW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  logic [CW-1:0]                 w_last;
  logic [RW-1:0]                 h_last;
  logic                          restart;
  logic                          s2_ready;
  logic                          s1_valid;
  logic [bfem_pkg::PIX_W-1:0]    s1_px;
  logic [bfem_pkg::PIX_W-1:0]    s1_a;
  logic [bfem_pkg::PIX_W-1:0]    s1_b;
  logic [RW-1:0]                 s1_row;
  logic [CW-1:0]                 s1_col;
  bfem_pkg::pos_flags_t          s1_flags;
  logic                          buf_free;
  logic                          s2_valid;
  bfem_pkg::win_t                s2_win;
  logic [RW-1:0]                 s2_row;
  logic [CW-1:0]                 s2_col;
  bfem_pkg::pos_flags_t          s2_flags;

  bfem_cfg #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .CW        (CW),
    .RW        (RW)
  ) u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .w_last (w_last),
    .h_last (h_last),
    .restart(restart)
  );

  bfem_front #(
    .MAX_WIDTH(MAX_WIDTH),
    .CW       (CW),
    .RW       (RW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_pixel_in(in_pixel_in),
    .w_last     (w_last),
    .h_last     (h_last),
    .restart    (restart),
    .s2_ready   (s2_ready),
    .s1_valid   (s1_valid),
    .s1_px      (s1_px),
    .s1_a       (s1_a),
    .s1_b       (s1_b),
    .s1_row     (s1_row),
    .s1_col     (s1_col),
    .s1_flags   (s1_flags)
  );

  bfem_window #(
    .CW(CW),
    .RW(RW)
  ) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .s1_valid(s1_valid),
    .s1_px   (s1_px),
    .s1_a    (s1_a),
    .s1_b    (s1_b),
    .s1_row  (s1_row),
    .s1_col  (s1_col),
    .s1_flags(s1_flags),
    .buf_free(buf_free),
    .s2_ready(s2_ready),
    .s2_valid(s2_valid),
    .s2_win  (s2_win),
    .s2_row  (s2_row),
    .s2_col  (s2_col),
    .s2_flags(s2_flags)
  );

  bfem_mean #(
    .CW(CW),
    .RW(RW)
  ) u_mean (
    .clk          (clk),
    .rst_n        (rst_n),
    .s2_valid     (s2_valid),
    .s2_win       (s2_win),
    .s2_row       (s2_row),
    .s2_col       (s2_col),
    .s2_flags     (s2_flags),
    .buf_free     (buf_free),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_mean_out (out_mean_out),
    .out_row      (out_row),
    .out_col      (out_col),
    .out_run_last (out_run_last),
    .out_frame_end(out_frame_end)
  );

endmodule

/* hdl/bfem_checker.sv */
module bfem_checker #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              psel,
  input logic                              penable,
  input logic                              pwrite,
  input logic [bfem_pkg::APB_AW-1:0]       paddr,
  input logic [bfem_pkg::APB_DW-1:0]       pwdata,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [bfem_pkg::PIX_W-1:0]        out_mean_out,
  input logic [bfem_pkg::ROW_OUT_W-1:0]    out_row,
  input logic [bfem_pkg::COL_OUT_W-1:0]    out_col,
  input logic                              out_run_last,
  input logic                              out_frame_end
);

  localparam logic REG_FRAME_WIDTH_SEL = bfem_pkg::REG_FRAME_WIDTH;

  logic [bfem_pkg::FW_W-1:0]      fw_r;
  logic [bfem_pkg::FH_W-1:0]      fh_r;
  int                             w_eff;
  int                             h_eff;
  logic [bfem_pkg::COL_OUT_W-1:0] exp_col;
  logic [bfem_pkg::ROW_OUT_W-1:0] exp_row;

  // shadow of the frame size as written on the port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= bfem_pkg::FW_W'(5);
      fh_r <= bfem_pkg::FH_W'(5);
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_FRAME_WIDTH_SEL) begin
        fw_r <= pwdata[bfem_pkg::FW_W-1:0];
      end else begin
        fh_r <= pwdata[bfem_pkg::FH_W-1:0];
      end
    end
  end

  always_comb begin
    w_eff = (fw_r == '0) ? 1 : ((int'(fw_r) > MAX_WIDTH)  ? MAX_WIDTH  : int'(fw_r));
    h_eff = (fh_r == '0) ? 1 : ((int'(fh_r) > MAX_HEIGHT) ? MAX_HEIGHT : int'(fh_r));
    exp_col = bfem_pkg::COL_OUT_W'(w_eff - 1);
    exp_row = bfem_pkg::ROW_OUT_W'(h_eff - 1);
  end

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mean_out)
                                && $stable(out_row) && $stable(out_col))
    else $error("stalled result changed");

  a_run_unbroken: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_run_last |=> out_valid)
    else $error("gap inside the results of one item");

  a_frame_end_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end && out_run_last |-> out_col == exp_col && out_row == exp_row)
    else $error("final result of frame not at the last pixel");

endmodule

bind box_filter_3x3_edge_mean bfem_checker #(
  .MAX_WIDTH (MAX_WIDTH),
  .MAX_HEIGHT(MAX_HEIGHT)
) u_bfem_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .psel         (psel),
  .penable      (penable),
  .pwrite       (pwrite),
  .paddr        (paddr),
  .pwdata       (pwdata),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_mean_out (out_mean_out),
  .out_row      (out_row),
  .out_col      (out_col),
  .out_run_last (out_run_last),
  .out_frame_end(out_frame_end)
);

/* test/tb_box_filter_3x3_edge_mean.sv */
`timescale 1ns / 100ps

module tb_box_filter_3x3_edge_mean;

  localparam int   PIX_W            = bfem_pkg::PIX_W;
  localparam int   ROW_OUT_W        = bfem_pkg::ROW_OUT_W;
  localparam int   COL_OUT_W        = bfem_pkg::COL_OUT_W;
  localparam int   FW_W             = bfem_pkg::FW_W;
  localparam int   FH_W             = bfem_pkg::FH_W;
  localparam int   APB_AW           = bfem_pkg::APB_AW;
  localparam int   APB_DW           = bfem_pkg::APB_DW;
  localparam logic REG_FRAME_WIDTH  = bfem_pkg::REG_FRAME_WIDTH;
  localparam logic REG_FRAME_HEIGHT = bfem_pkg::REG_FRAME_HEIGHT;

  localparam int MAX_W          = 1024;
  localparam int MAX_H          = 4096;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 4000;

  localparam logic [APB_AW-1:0] ADDR_FRAME_WIDTH  = {REG_FRAME_WIDTH, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_FRAME_HEIGHT = {REG_FRAME_HEIGHT, 2'b00};

  typedef struct packed {
    logic [PIX_W-1:0]     mean;
    logic [ROW_OUT_W-1:0] row;
    logic [COL_OUT_W-1:0] col;
    logic                 run_last;
    logic                 frame_end;
  } filtered_px_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [APB_AW-1:0]    paddr = '0;
  logic [APB_DW-1:0]    pwdata = '0;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [PIX_W-1:0]     in_pixel_in = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [PIX_W-1:0]     out_mean_out;
  logic [ROW_OUT_W-1:0] out_row;
  logic [COL_OUT_W-1:0] out_col;
  logic                 out_run_last;
  logic                 out_frame_end;

  box_filter_3x3_edge_mean #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_pixel_in  (in_pixel_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_mean_out (out_mean_out),
    .out_row      (out_row),
    .out_col      (out_col),
    .out_run_last (out_run_last),
    .out_frame_end(out_frame_end)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // filter model state
  logic [PIX_W-1:0] row_above [MAX_W];
  logic [PIX_W-1:0] row_above2[MAX_W];
  logic [PIX_W-1:0] nbhd[9];
  int unsigned      next_row;
  int unsigned      next_col;
  logic [FW_W-1:0]  cfg_width;
  logic [FH_W-1:0]  cfg_height;

  filtered_px_t expected_means[$];
  int           mismatches = 0;
  int           idle_cycles = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned max_v);
    if (v == 0) return 1;
    if (v > max_v) return max_v;
    return v;
  endfunction

  // mean over the in-frame part of the neighbourhood centred at window (wi,wj)
  function automatic logic [PIX_W-1:0] nbhd_mean(int wi, int wj, int r, int c,
                                                 int h, int w);
    int sum;
    int cnt;
    int i;
    int j;
    int di;
    int dj;
    sum = 0;
    cnt = 0;
    for (di = -1; di <= 1; di++) begin
      for (dj = -1; dj <= 1; dj++) begin
        i = wi + di;
        j = wj + dj;
        if (i >= 0 && i <= 2 && j >= 0 && j <= 2 &&
            r - 2 + i >= 0 && r - 2 + i < h && c - 2 + j >= 0 && c - 2 + j < w) begin
          sum += nbhd[i * 3 + j];
          cnt++;
        end
      end
    end
    if (cnt == 0) return '0;
    return PIX_W'(sum / cnt);
  endfunction

  task automatic filter_pixel(input logic [PIX_W-1:0] px);
    int           w;
    int           h;
    int           r;
    int           c;
    int           wrows[2];
    int           wcols[2];
    int           nr;
    int           nc;
    int           n;
    logic [PIX_W-1:0] a;
    logic [PIX_W-1:0] b;
    logic         fend;
    filtered_px_t res[4];
    w = clamp_dim(cfg_width, MAX_W);
    h = clamp_dim(cfg_height, MAX_H);
    r = next_row;
    c = next_col;
    nr = 0;
    nc = 0;
    n = 0;
    if (r >= h || c >= w) begin
      r = 0;
      c = 0;
    end
    a = row_above[c];
    b = row_above2[c];
    row_above2[c] = a;
    row_above[c] = px;
    for (int i = 0; i < 3; i++) begin
      nbhd[i * 3 + 0] = nbhd[i * 3 + 1];
      nbhd[i * 3 + 1] = nbhd[i * 3 + 2];
    end
    nbhd[2] = b;
    nbhd[5] = a;
    nbhd[8] = px;
    if (r >= 1) wrows[nr++] = 1;
    if (r == h - 1) wrows[nr++] = 2;
    if (c >= 1) wcols[nc++] = 1;
    if (c == w - 1) wcols[nc++] = 2;
    fend = (r == h - 1) && (c == w - 1);
    for (int i = 0; i < nr; i++) begin
      for (int k = 0; k < nc; k++) begin
        res[n].mean      = nbhd_mean(wrows[i], wcols[k], r, c, h, w);
        res[n].row       = ROW_OUT_W'(r - 2 + wrows[i]);
        res[n].col       = COL_OUT_W'(c - 2 + wcols[k]);
        res[n].run_last  = 1'b0;
        res[n].frame_end = fend;
        n++;
      end
    end
    if (n > 0) res[n - 1].run_last = 1'b1;
    for (int i = 0; i < n; i++) expected_means.push_back(res[i]);
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    next_row = r;
    next_col = c;
  endtask

  function automatic logic [PIX_W-1:0] rand_pixel();
    if ($urandom_range(3) == 0) return $urandom_range(1) ? 8'hFF : 8'h00;
    return PIX_W'($urandom_range(255));
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_in <= px;
    do @(posedge clk); while (!in_ready);
    filter_pixel(px);
  endtask

  // hold the input until every expected item is out, then let the pipe settle
  task automatic await_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_means.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    await_results();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr[2] == REG_FRAME_WIDTH) cfg_width = data[FW_W-1:0];
    else cfg_height = data[FH_W-1:0];
    next_row = 0;
    next_col = 0;
  endtask

  task automatic set_frame(input int unsigned w, input int unsigned h);
    write_reg(ADDR_FRAME_WIDTH, w);
    write_reg(ADDR_FRAME_HEIGHT, h);
  endtask

  // reset size of 5x5; extremes, early rows and the four-result flush
  task automatic test_default_frame();
    for (int i = 0; i < 25; i++) begin
      case (i % 3)
        0: send_pixel(8'hFF);
        1: send_pixel(8'h00);
        default: send_pixel(PIX_W'(i * 37));
      endcase
    end
  endtask

  // zero width and height both act as one
  task automatic test_zero_size();
    set_frame(0, 0);
    send_pixel(8'hFF);
    send_pixel(8'h00);
    send_pixel(8'h5A);
    send_pixel(8'hA5);
  endtask

  // a register write mid-frame starts a new frame
  task automatic test_restart_mid_frame();
    set_frame(4, 3);
    repeat (6) send_pixel(rand_pixel());
    write_reg(ADDR_FRAME_WIDTH, 4);
    repeat (24) send_pixel(rand_pixel());
  endtask

  // register values above the maximum and at the maximum
  task automatic test_oversize_frames();
    set_frame(2047, 1);
    repeat (70) send_pixel(rand_pixel());
    set_frame(1, 8191);
    repeat (60) send_pixel(rand_pixel());
    set_frame(MAX_W, MAX_H);
    repeat (40) send_pixel(rand_pixel());
  endtask

  // mostly whole frames, some wrapping into a second frame, some cut short
  task automatic test_random_frames(input int n_items);
    int sent;
    int w;
    int h;
    int n;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(5) == 0) begin
        w = $urandom_range(13, 64);
        h = $urandom_range(0, 3);
      end else begin
        w = $urandom_range(0, 12);
        h = $urandom_range(0, 8);
      end
      set_frame(w, h);
      n = clamp_dim(w, MAX_W) * clamp_dim(h, MAX_H);
      if ($urandom_range(3) == 0) n = $urandom_range(1, n);
      else n = n * $urandom_range(1, 2);
      if (n > n_items - sent) n = n_items - sent;
      repeat (n) send_pixel(rand_pixel());
      sent += n;
    end
  endtask

  // result side: random stall, compare each item with the oldest prediction
  always @(posedge clk) begin
    filtered_px_t got;
    filtered_px_t want;
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_n && out_valid && out_ready) begin
      got = {out_mean_out, out_row, out_col, out_run_last, out_frame_end};
      if (expected_means.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item: mean %0d row %0d col %0d last %0b end %0b",
                   got.mean, got.row, got.col, got.run_last, got.frame_end);
      end else begin
        want = expected_means.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp mean %0d row %0d col %0d last %0b end %0b,",
                     want.mean, want.row, want.col, want.run_last, want.frame_end,
                     " got mean %0d row %0d col %0d last %0b end %0b",
                     got.mean, got.row, got.col, got.run_last, got.frame_end);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < MAX_W; i++) begin
      row_above[i] = '0;
      row_above2[i] = '0;
    end
    for (int i = 0; i < 9; i++) nbhd[i] = '0;
    next_row = 0;
    next_col = 0;
    cfg_width = 5;
    cfg_height = 5;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 23;
    recv_idle_pct = 81;
    test_default_frame();
    test_zero_size();
    test_restart_mid_frame();
    test_random_frames(80);

    send_idle_pct = 81;
    recv_idle_pct = 23;
    test_oversize_frames();
    test_random_frames(80);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_frames(70);

    await_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_means.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* box_filter_3x3_edge_mean.f */
hdl/bfem_pkg.sv
hdl/bfem_cfg.sv
hdl/bfem_front.sv
hdl/bfem_window.sv
hdl/bfem_mean.sv
hdl/box_filter_3x3_edge_mean.sv
hdl/bfem_checker.sv
test/tb_box_filter_3x3_edge_mean.sv
